[hdl/fbpa_pkg.sv]
// Shared types, constants and helpers for the fixed block pool allocator.
// No dependencies; every other file in hdl/ imports this package.
package fbpa_pkg;

  localparam int unsigned MaxBlocksDefault = 256;

  // Reset values of the configuration registers
  localparam logic [8:0]  PoolBlocksReset = 9'd256;
  localparam logic [16:0] BlockSizeReset  = 17'd8;
  localparam logic [3:0]  AlignLog2Reset  = 4'd3;
  localparam logic [31:0] BaseAddrReset   = 32'd0;

  typedef enum logic [1:0] {
    REG_POOL_BLOCKS = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_ALIGN_LOG2  = 2'd2,
    REG_BASE_ADDR   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [8:0]  pool_blocks;
    logic [16:0] blk_bytes;
    logic [3:0]  align_log2;
    logic [31:0] base_address;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  granted_index;
    logic [32:0] granted_address;
    logic [8:0]  used_count;
  } result_t;

  // Block pitch: size raised to 8, rounded up to 2^clamp(align_log2, 3, 12)
  function automatic logic [17:0] stride_of(logic [16:0] size, logic [3:0] align_log2);
    logic [3:0]  al;
    logic [17:0] sz;
    logic [17:0] mask;
    al = (align_log2 < 4'd3) ? 4'd3 : ((align_log2 > 4'd12) ? 4'd12 : align_log2);
    sz = (size < 17'd8) ? 18'd8 : {1'b0, size};
    mask = (18'd1 << al) - 18'd1;
    return (sz + mask) & ~mask;
  endfunction

endpackage

[hdl/fbpa_regs.sv]
// APB-style configuration register file of the block pool allocator.
// Depends on fbpa_pkg for the register map and the cfg_t bundle.
module fbpa_regs import fbpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o,
  output logic        pool_write_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  reg_idx_e   idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_blocks  <= PoolBlocksReset;
      cfg_q.blk_bytes    <= BlockSizeReset;
      cfg_q.align_log2   <= AlignLog2Reset;
      cfg_q.base_address <= BaseAddrReset;
    end else if (wr_en) begin
      case (idx)
        REG_POOL_BLOCKS: cfg_q.pool_blocks  <= pwdata[8:0];
        REG_BLOCK_SIZE:  cfg_q.blk_bytes    <= pwdata[16:0];
        REG_ALIGN_LOG2:  cfg_q.align_log2   <= pwdata[3:0];
        REG_BASE_ADDR:   cfg_q.base_address <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POOL_BLOCKS: prdata = 32'(cfg_q.pool_blocks);
      REG_BLOCK_SIZE:  prdata = 32'(cfg_q.blk_bytes);
      REG_ALIGN_LOG2:  prdata = 32'(cfg_q.align_log2);
      REG_BASE_ADDR:   prdata = cfg_q.base_address;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o        = cfg_q;
  assign pool_write_o = wr_en && (idx == REG_POOL_BLOCKS);

endmodule

[hdl/fbpa_link_ram.sv]
// Free-list link memory: one write port, one registered read port with
// write-to-read bypass. Depends on fbpa_pkg only for the default depth.
module fbpa_link_ram import fbpa_pkg::*; #(
  parameter int unsigned DEPTH = MaxBlocksDefault,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    // a push makes the written entry the new top: forward it
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hdl/fbpa_engine.sv]
// Allocator state and result register: LIFO free stack, fresh counter,
// outstanding count and address computation. Depends on fbpa_pkg, fbpa_link_ram.
module fbpa_engine import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       clear_i,
  input  logic       action_i,
  input  logic [7:0] index_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int unsigned LinkDepth = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int unsigned AddrW     = $clog2(LinkDepth);
  localparam logic [8:0]  PoolLimit = 9'(LinkDepth);

  logic [7:0]  top_q, top_d;
  logic        nonempty_q, nonempty_d;
  logic [8:0]  fresh_q, fresh_d;
  logic [8:0]  outst_q, outst_d;
  logic [7:0]  link;
  result_t     res_q, res_d;

  logic [8:0]  n_eff;
  logic [17:0] stride;
  logic [7:0]  gidx;
  logic [25:0] offset;
  logic        wr_en;

  assign n_eff = (cfg_i.pool_blocks == 9'd0) ? 9'd1 :
                 ((cfg_i.pool_blocks > PoolLimit) ? PoolLimit : cfg_i.pool_blocks);
  assign stride = stride_of(cfg_i.blk_bytes, cfg_i.align_log2);

  always_comb begin
    top_d    = top_q;
    fresh_d  = fresh_q;
    outst_d  = outst_q;
    gidx     = 8'd0;
    wr_en    = 1'b0;
    res_d    = res_q;
    if (clear_i) begin
      top_d   = 8'd0;
      fresh_d = 9'd0;
      outst_d = 9'd0;
    end else if (fire_i) begin
      res_d.status = ST_OK;
      if (!action_i) begin
        if (nonempty_q) begin
          gidx  = top_q;
          top_d = link;
        end else if (fresh_q < n_eff) begin
          gidx    = fresh_q[7:0];
          fresh_d = fresh_q + 9'd1;
        end else begin
          res_d.status = ST_EMPTY;
        end
        if (res_d.status == ST_OK) begin
          outst_d = outst_q + 9'd1;
        end
      end else begin
        if ((outst_q == 9'd0) || ({1'b0, index_i} >= n_eff)) begin
          res_d.status = ST_INVALID;
        end else begin
          wr_en   = 1'b1;
          top_d   = index_i;
          outst_d = outst_q - 9'd1;
        end
      end
    end
    offset = 26'(gidx) * 26'(stride);
    if (fire_i && !clear_i) begin
      res_d.granted_index   = gidx;
      res_d.granted_address = (res_d.status == ST_OK && !action_i) ?
                              ({1'b0, cfg_i.base_address} + 33'(offset)) : 33'd0;
      res_d.used_count      = outst_d;
    end
    // stack depth is fresh minus outstanding
    nonempty_d = fresh_d > outst_d;
  end

  fbpa_link_ram #(.DEPTH(LinkDepth)) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (index_i[AddrW-1:0]),
    .wr_data_i (top_q),
    .rd_addr_i (top_d[AddrW-1:0]),
    .rd_data_o (link)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= 8'd0;
      nonempty_q <= 1'b0;
      fresh_q    <= 9'd0;
      outst_q    <= 9'd0;
    end else begin
      top_q      <= top_d;
      nonempty_q <= nonempty_d;
      fresh_q    <= fresh_d;
      outst_q    <= outst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

[hdl/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator: acquire pops a LIFO free list (freed blocks
// are reused before fresh ones 0,1,2,...), release pushes onto it; each result
// carries the block index, its address base + index * stride and the outstanding
// count. One item per clock is sustained while out_ready_i stays high; an accepted
// item passes the input register, then the result register. The rate is set by
// the top-of-stack pop, which needs the link of the current top each cycle and
// gets it from the link memory's registered read addressed by the next top.
// Writing pool_blocks frees every block. No clearing pass is needed after reset.
// Depends on fbpa_pkg, fbpa_regs, fbpa_link_ram and fbpa_engine.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  block_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  granted_index_o,
  output logic [32:0] granted_address_o,
  output logic [8:0]  used_count_o
);

  localparam int unsigned LinkDepth = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

  cfg_t       cfg;
  logic       pool_write;
  logic       in_valid_q, out_valid_q;
  logic       action_q;
  logic [7:0] index_q;
  logic       fire;
  result_t    result;

  fbpa_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cfg_o        (cfg),
    .pool_write_o (pool_write)
  );

  // advance the held item when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      index_q  <= block_index_i;
    end
  end

  fbpa_engine #(.MAX_BLOCKS(MAX_BLOCKS)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .clear_i  (pool_write),
    .action_i (action_q),
    .index_i  (index_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = result.status;
  assign granted_index_o   = result.granted_index;
  assign granted_address_o = result.granted_address;
  assign used_count_o      = result.used_count;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (used_count_o <= 9'(LinkDepth)))
    else $error("outstanding count exceeds pool capacity");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      ((granted_index_o == 8'd0) && (granted_address_o == 33'd0)))
    else $error("failed item carries a grant");

  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("advanced item produced no result");

endmodule
